>>> rtl/core/tte_pkg.sv
// Shared types, constants and the month offset table of the timestamp converter.
package tte_pkg;

    // One parsed string handed from the character front end to the date back end.
    typedef struct packed {
        logic        ok;
        logic [13:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
        logic [9:0]  ms;
    } tte_job_t;

    typedef enum logic [3:0] {
        BK_IDLE,
        BK_DIV,
        BK_FIX,
        BK_DOE,
        BK_DAYS,
        BK_HOUR,
        BK_MIN,
        BK_MS,
        BK_VAL,
        BK_OUT
    } tte_back_state_t;

    // civil date constants
    localparam int unsigned ERA_DAYS     = 146097;
    localparam int unsigned EPOCH_OFFSET = 719468;
    localparam int unsigned DIV400_MUL   = 41944;   // ceil(2^24 / 400), exact for y < 10000
    localparam int unsigned DIV400_SHIFT = 24;

    // day of year at the first of a March-based month: (153 * mp + 2) / 5
    function automatic logic [8:0] doy_base(input logic [3:0] mp);
        logic [8:0] r;
        case (mp)
            4'd0:    r = 9'd0;
            4'd1:    r = 9'd31;
            4'd2:    r = 9'd61;
            4'd3:    r = 9'd92;
            4'd4:    r = 9'd122;
            4'd5:    r = 9'd153;
            4'd6:    r = 9'd184;
            4'd7:    r = 9'd214;
            4'd8:    r = 9'd245;
            4'd9:    r = 9'd275;
            4'd10:   r = 9'd306;
            4'd11:   r = 9'd337;
            default: r = 9'd0;
        endcase
        return r;
    endfunction

endpackage

>>> rtl/core/tte_front.sv
// Character front end: trims, checks the fixed layout and gathers digit fields.
module tte_front
    import tte_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,
    input  logic        s_tlast,
    input  logic        q_ready,
    output logic        q_push,
    output tte_job_t    q_job
);

    localparam logic [15:0] CH_TAB    = 16'd9;
    localparam logic [15:0] CH_CR     = 16'd13;
    localparam logic [15:0] CH_SPACE  = 16'd32;
    localparam logic [15:0] CH_DQUOTE = 16'd34;
    localparam logic [15:0] CH_SQUOTE = 16'd39;
    localparam logic [15:0] CH_DASH   = 16'd45;
    localparam logic [15:0] CH_DOT    = 16'd46;
    localparam logic [15:0] CH_ZERO   = 16'd48;
    localparam logic [15:0] CH_NINE   = 16'd57;
    localparam logic [15:0] CH_COLON  = 16'd58;
    localparam logic [15:0] CH_T      = 16'd84;

    localparam logic [1:0] QK_NONE   = 2'd0;
    localparam logic [1:0] QK_DOUBLE = 2'd1;
    localparam logic [1:0] QK_SINGLE = 2'd2;

    localparam logic [4:0] POS_SAT = 5'd24;

    logic        seen_reg,       seen_next;
    logic [1:0]  quote_reg,      quote_next;
    logic [4:0]  pos_reg,        pos_next;
    logic        layout_reg,     layout_next;
    logic [13:0] year_reg,       year_next;
    logic [6:0]  month_reg,      month_next;
    logic [6:0]  day_reg,        day_next;
    logic [6:0]  hour_reg,       hour_next;
    logic [6:0]  minute_reg,     minute_next;
    logic [6:0]  second_reg,     second_next;
    logic [9:0]  milli_reg,      milli_next;
    logic        milli_good_reg, milli_good_next;
    logic        dot_reg,        dot_next;
    logic [4:0]  lnp_reg,        lnp_next;
    logic [15:0] lnc_reg,        lnc_next;

    logic        accept;
    logic        take;
    logic        ws;
    logic        digit;
    logic [3:0]  d;
    logic        match;
    logic [4:0]  size;
    logic        ok;
    logic        ms_take;

    assign s_tready = q_ready;
    assign accept   = s_tvalid && q_ready;
    assign q_push   = accept && s_tlast;

    always_comb begin
        seen_next       = seen_reg;
        quote_next      = quote_reg;
        pos_next        = pos_reg;
        layout_next     = layout_reg;
        year_next       = year_reg;
        month_next      = month_reg;
        day_next        = day_reg;
        hour_next       = hour_reg;
        minute_next     = minute_reg;
        second_next     = second_reg;
        milli_next      = milli_reg;
        milli_good_next = milli_good_reg;
        dot_next        = dot_reg;
        lnp_next        = lnp_reg;
        lnc_next        = lnc_reg;
        take            = 1'b0;

        ws    = (s_tdata == CH_SPACE) || (s_tdata >= CH_TAB && s_tdata <= CH_CR);
        digit = (s_tdata >= CH_ZERO) && (s_tdata <= CH_NINE);
        d     = s_tdata[3:0];

        if (accept) begin
            if (!seen_reg) begin
                if (!ws) begin
                    seen_next = 1'b1;
                    if (s_tdata == CH_DQUOTE) begin
                        quote_next = QK_DOUBLE;
                    end else if (s_tdata == CH_SQUOTE) begin
                        quote_next = QK_SINGLE;
                    end else begin
                        take = 1'b1;
                    end
                end
            end else begin
                take = 1'b1;
            end
        end

        if (take) begin
            if (pos_reg <= 5'd18) begin
                if (pos_reg inside {5'd4, 5'd7}) begin
                    if (s_tdata != CH_DASH) layout_next = 1'b0;
                end else if (pos_reg == 5'd10) begin
                    if (s_tdata != CH_SPACE && s_tdata != CH_T) layout_next = 1'b0;
                end else if (pos_reg inside {5'd13, 5'd16}) begin
                    if (s_tdata != CH_COLON) layout_next = 1'b0;
                end else if (!digit) begin
                    layout_next = 1'b0;
                end else if (pos_reg <= 5'd3) begin
                    year_next = 14'(year_reg * 14'd10 + 14'(d));
                end else if (pos_reg <= 5'd6) begin
                    month_next = 7'(month_reg * 7'd10 + 7'(d));
                end else if (pos_reg <= 5'd9) begin
                    day_next = 7'(day_reg * 7'd10 + 7'(d));
                end else if (pos_reg <= 5'd12) begin
                    hour_next = 7'(hour_reg * 7'd10 + 7'(d));
                end else if (pos_reg <= 5'd15) begin
                    minute_next = 7'(minute_reg * 7'd10 + 7'(d));
                end else begin
                    second_next = 7'(second_reg * 7'd10 + 7'(d));
                end
            end else if (pos_reg == 5'd19) begin
                dot_next = (s_tdata == CH_DOT);
            end else if (pos_reg <= 5'd22) begin
                if (digit) milli_next = 10'(milli_reg * 10'd10 + 10'(d));
                else       milli_good_next = 1'b0;
            end
            if (!ws) begin
                lnp_next = pos_reg;
                lnc_next = s_tdata;
            end
            if (pos_reg < POS_SAT) pos_next = pos_reg + 5'd1;
        end

        // end-of-string verdict, taken on the state that includes this character
        if (quote_next != QK_NONE) begin
            match = (lnc_next == ((quote_next == QK_DOUBLE) ? CH_DQUOTE : CH_SQUOTE));
            size  = lnp_next;
        end else begin
            match = 1'b1;
            size  = seen_next ? lnp_next + 5'd1 : 5'd0;
        end

        ok = match && (size >= 5'd19) && layout_next &&
             (month_next >= 7'd1) && (month_next <= 7'd12) &&
             (day_next >= 7'd1) && (day_next <= 7'd31) &&
             (hour_next <= 7'd23) && (minute_next <= 7'd59) && (second_next <= 7'd60);
        ms_take = (size >= 5'd23) && dot_next && milli_good_next;

        q_job.ok     = ok;
        q_job.year   = year_next;
        q_job.month  = month_next[3:0];
        q_job.day    = day_next[4:0];
        q_job.hour   = hour_next[4:0];
        q_job.minute = minute_next[5:0];
        q_job.second = second_next[5:0];
        q_job.ms     = ms_take ? milli_next : 10'd0;

        // string done: start over
        if (q_push) begin
            seen_next       = 1'b0;
            quote_next      = QK_NONE;
            pos_next        = 5'd0;
            layout_next     = 1'b1;
            year_next       = '0;
            month_next      = '0;
            day_next        = '0;
            hour_next       = '0;
            minute_next     = '0;
            second_next     = '0;
            milli_next      = '0;
            milli_good_next = 1'b1;
            dot_next        = 1'b0;
            lnp_next        = '0;
            lnc_next        = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seen_reg       <= 1'b0;
            quote_reg      <= QK_NONE;
            pos_reg        <= 5'd0;
            layout_reg     <= 1'b1;
            year_reg       <= '0;
            month_reg      <= '0;
            day_reg        <= '0;
            hour_reg       <= '0;
            minute_reg     <= '0;
            second_reg     <= '0;
            milli_reg      <= '0;
            milli_good_reg <= 1'b1;
            dot_reg        <= 1'b0;
            lnp_reg        <= '0;
            lnc_reg        <= '0;
        end else begin
            seen_reg       <= seen_next;
            quote_reg      <= quote_next;
            pos_reg        <= pos_next;
            layout_reg     <= layout_next;
            year_reg       <= year_next;
            month_reg      <= month_next;
            day_reg        <= day_next;
            hour_reg       <= hour_next;
            minute_reg     <= minute_next;
            second_reg     <= second_next;
            milli_reg      <= milli_next;
            milli_good_reg <= milli_good_next;
            dot_reg        <= dot_next;
            lnp_reg        <= lnp_next;
            lnc_reg        <= lnc_next;
        end
    end

endmodule

>>> rtl/core/tte_queue.sv
// Small FIFO of parsed strings between front end and back end.
module tte_queue
    import tte_pkg::*;
#(
    parameter int DEPTH = 2
) (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     push,
    input  tte_job_t push_data,
    output logic     ready,
    input  logic     pop,
    output logic     valid,
    output tte_job_t pop_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    tte_job_t           slot_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg,  count_next;
    logic               do_push;
    logic               do_pop;

    assign ready    = (count_reg != CNT_W'(DEPTH));
    assign valid    = (count_reg != '0);
    assign do_push  = push && ready;
    assign do_pop   = pop && valid;
    assign pop_data = slot_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) slot_reg[wr_ptr_reg] <= push_data;
    end

endmodule

>>> rtl/core/tte_back.sv
// Date back end: civil-date day count and millisecond assembly, one step per cycle.
module tte_back
    import tte_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        q_valid,
    input  tte_job_t    q_job,
    output logic        q_pop,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,
    output logic        m_tuser
);

    tte_back_state_t    state_reg, state_next;
    tte_job_t           job_reg,   job_next;

    logic [13:0]        y_reg,        y_next;
    logic               neg_reg,      neg_next;
    logic [4:0]         q_reg,        q_next;
    logic signed [5:0]  era_reg,      era_next;
    logic [8:0]         yoe_reg,      yoe_next;
    logic [8:0]         doy_reg,      doy_next;
    logic [17:0]        doe_reg,      doe_next;
    logic signed [23:0] era_days_reg, era_days_next;
    logic signed [23:0] days_reg,     days_next;
    logic signed [28:0] mh_reg,       mh_next;
    logic signed [34:0] mm_reg,       mm_next;
    logic               status_reg,   status_next;
    logic [48:0]        value_reg,    value_next;

    logic               adj;
    logic [29:0]        div_prod;
    logic [3:0]         mp;
    logic [1:0]         c100;
    logic [16:0]        sec_ms;
    logic signed [48:0] v;

    assign q_pop    = (state_reg == BK_IDLE) && q_valid;
    assign m_tvalid = (state_reg == BK_OUT);
    assign m_tdata  = {7'd0, value_reg};
    assign m_tuser  = status_reg;

    always_comb begin
        state_next    = state_reg;
        job_next      = job_reg;
        y_next        = y_reg;
        neg_next      = neg_reg;
        q_next        = q_reg;
        era_next      = era_reg;
        yoe_next      = yoe_reg;
        doy_next      = doy_reg;
        doe_next      = doe_reg;
        era_days_next = era_days_reg;
        days_next     = days_reg;
        mh_next       = mh_reg;
        mm_next       = mm_reg;
        status_next   = status_reg;
        value_next    = value_reg;

        adj      = (job_reg.month <= 4'd2);
        div_prod = 30'(y_reg) * 30'(DIV400_MUL);
        mp       = (job_reg.month > 4'd2) ? job_reg.month - 4'd3 : job_reg.month + 4'd9;
        c100     = (yoe_reg >= 9'd300) ? 2'd3 :
                   (yoe_reg >= 9'd200) ? 2'd2 :
                   (yoe_reg >= 9'd100) ? 2'd1 : 2'd0;
        sec_ms   = 17'(17'(job_reg.second) * 17'd1000) + 17'(job_reg.ms);
        v        = 49'(mm_reg) * 49'sd60000 + $signed({32'd0, sec_ms});

        case (state_reg)
            BK_IDLE: begin
                if (q_valid) begin
                    job_next = q_job;
                    if (q_job.ok) begin
                        state_next = BK_DIV;
                    end else begin
                        status_next = 1'b1;
                        value_next  = '0;
                        state_next  = BK_OUT;
                    end
                end
            end
            BK_DIV: begin
                // Jan and Feb count in the previous year; year 0 then goes negative
                y_next     = job_reg.year - 14'(adj);
                neg_next   = adj && (job_reg.year == 14'd0);
                state_next = BK_FIX;
            end
            BK_FIX: begin
                q_next     = div_prod[DIV400_SHIFT+4:DIV400_SHIFT];
                state_next = BK_DOE;
            end
            BK_DOE: begin
                if (neg_reg) begin
                    era_next = -6'sd1;
                    yoe_next = 9'd399;
                end else begin
                    era_next = $signed({1'b0, q_reg});
                    yoe_next = 9'(y_reg - 14'(14'(q_reg) * 14'd400));
                end
                doy_next   = doy_base(mp) + 9'(job_reg.day) - 9'd1;
                state_next = BK_DAYS;
            end
            BK_DAYS: begin
                doe_next      = 18'(18'(yoe_reg) * 18'd365) + 18'(yoe_reg[8:2])
                              - 18'(c100) + 18'(doy_reg);
                era_days_next = 24'(era_reg) * 24'sd146097;
                state_next    = BK_HOUR;
            end
            BK_HOUR: begin
                days_next  = era_days_reg + $signed({6'd0, doe_reg})
                           - $signed(24'(EPOCH_OFFSET));
                state_next = BK_MIN;
            end
            BK_MIN: begin
                mh_next    = 29'(days_reg) * 29'sd24 + $signed({24'd0, job_reg.hour});
                state_next = BK_MS;
            end
            BK_MS: begin
                mm_next    = 35'(mh_reg) * 35'sd60 + $signed({29'd0, job_reg.minute});
                state_next = BK_VAL;
            end
            BK_VAL: begin
                // minutes to ms, plus seconds and milliseconds
                value_next  = 49'(v);
                status_next = 1'b0;
                state_next  = BK_OUT;
            end
            BK_OUT: begin
                if (m_tready) state_next = BK_IDLE;
            end
            default: state_next = BK_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) state_reg <= BK_IDLE;
        else          state_reg <= state_next;
    end

    always_ff @(posedge aclk) begin
        job_reg      <= job_next;
        y_reg        <= y_next;
        neg_reg      <= neg_next;
        q_reg        <= q_next;
        era_reg      <= era_next;
        yoe_reg      <= yoe_next;
        doy_reg      <= doy_next;
        doe_reg      <= doe_next;
        era_days_reg <= era_days_next;
        days_reg     <= days_next;
        mh_reg       <= mh_next;
        mm_reg       <= mm_next;
        status_reg   <= status_next;
        value_reg    <= value_next;
    end

endmodule

>>> rtl/core/timestamp_text_to_epoch_ms.sv
// Top level: timestamp text stream in, epoch milliseconds result out.
//
//  channel | dir | tdata                      | tuser          | tlast
//  --------+-----+----------------------------+----------------+------------------
//  s_      | in  | [15:0] char_code           | -              | is_last
//  m_      | out | [48:0] epoch_ms, [55:49] 0 | [0] status     | -
//
// The front end takes one character per cycle; s_tready drops only while the
// string queue is full. A good string takes pop, eight arithmetic steps and
// output in the back end, a rejected one pop and output; no string is popped
// until the last result is taken; the step sequencer sets the string rate.
// Reset is synchronous, active low, and empties the queue. A stalled m_
// transaction holds the back end, not the front end until the queue fills.
module timestamp_text_to_epoch_ms
    import tte_pkg::*;
#(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,    // [15:0] char_code
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,    // [48:0] epoch_ms, [55:49] zero
    output logic        m_tuser     // [0] status
);

    tte_job_t push_job;
    tte_job_t pop_job;
    logic     push;
    logic     q_ready;
    logic     q_valid;
    logic     q_pop;

    tte_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .q_ready  (q_ready),
        .q_push   (push),
        .q_job    (push_job)
    );

    tte_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (push_job),
        .ready     (q_ready),
        .pop       (q_pop),
        .valid     (q_valid),
        .pop_data  (pop_job)
    );

    tte_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (q_valid),
        .q_job    (pop_job),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

`ifndef SYNTHESIS
    // a rejected string always reports zero
    a_fail_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tdata == 56'd0)
        else $error("failure result with nonzero value");

    // good results stay within years 0000..9999
    a_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |->
            $signed(m_tdata[48:0]) >= -49'sd62167219200000 &&
            $signed(m_tdata[48:0]) <= 49'sd253402300800999)
        else $error("epoch result out of range");

    // the front end only stalls when the queue has no room
    a_stall_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> !q_ready && q_valid)
        else $error("input stalled with queue space free");
`endif

endmodule

>>> test/epoch_scoreboard_pkg.sv
// Character constants and the scoreboard that predicts and checks epoch results.
package epoch_scoreboard_pkg;

    timeunit 1ns;
    timeprecision 1ps;

    localparam bit [15:0] CH_TAB    = 16'd9;
    localparam bit [15:0] CH_CR     = 16'd13;
    localparam bit [15:0] CH_SPACE  = 16'd32;
    localparam bit [15:0] CH_DQUOTE = 16'd34;
    localparam bit [15:0] CH_SQUOTE = 16'd39;
    localparam bit [15:0] CH_DASH   = 16'd45;
    localparam bit [15:0] CH_DOT    = 16'd46;
    localparam bit [15:0] CH_ZERO   = 16'd48;
    localparam bit [15:0] CH_NINE   = 16'd57;
    localparam bit [15:0] CH_COLON  = 16'd58;
    localparam bit [15:0] CH_T      = 16'd84;

    localparam bit ST_CONVERTED = 1'b0;
    localparam bit ST_FALLBACK  = 1'b1;

    localparam int CONTENT_CAP = 24;

    typedef enum bit [1:0] {
        QT_NONE,
        QT_DOUBLE,
        QT_SINGLE
    } quote_t;

    class epoch_scoreboard;
        typedef struct {
            bit        status;
            bit [48:0] epoch_ms;
        } stamp_t;

        stamp_t due_stamps[$];
        int     errors;
        int     n_checked;
        int     n_converted;
        int     n_fallback;

        // parser state, one string at a time
        bit        seen_text;
        quote_t    quote;
        bit [4:0]  pos;
        bit        layout_ok;
        bit [13:0] year;
        bit [6:0]  month, day, hour, minute, second;
        bit [9:0]  milli;
        bit        milli_ok;
        bit        dot_seen;
        bit [4:0]  mark_pos;
        bit [15:0] mark_char;

        function new();
            clear();
        endfunction

        function void clear();
            seen_text = 1'b0;
            quote     = QT_NONE;
            pos       = '0;
            layout_ok = 1'b1;
            year      = '0;
            month     = '0;
            day       = '0;
            hour      = '0;
            minute    = '0;
            second    = '0;
            milli     = '0;
            milli_ok  = 1'b1;
            dot_seen  = 1'b0;
            mark_pos  = '0;
            mark_char = '0;
        endfunction

        static function bit is_space(bit [15:0] c);
            return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
        endfunction

        static function bit is_digit(bit [15:0] c);
            return c >= CH_ZERO && c <= CH_NINE;
        endfunction

        // days since 1970-01-01 of a proleptic Gregorian date
        static function longint days_from_epoch(longint y, longint m, longint d);
            longint era, yoe, doy, doe;
            if (m <= 2) y -= 1;
            era = (y >= 0 ? y : y - 399) / 400;
            yoe = y - era * 400;
            doy = (153 * (m + (m > 2 ? -3 : 9)) + 2) / 5 + d - 1;
            doe = yoe * 365 + yoe / 4 - yoe / 100 + doy;
            return era * 146097 + doe - 719468;
        endfunction

        function void take_content(bit [15:0] c);
            bit [4:0]  p;
            bit [15:0] d;
            p = pos;
            d = c - CH_ZERO;
            if (p <= 18) begin
                if (p == 4 || p == 7) begin
                    if (c != CH_DASH) layout_ok = 1'b0;
                end else if (p == 10) begin
                    if (c != CH_SPACE && c != CH_T) layout_ok = 1'b0;
                end else if (p == 13 || p == 16) begin
                    if (c != CH_COLON) layout_ok = 1'b0;
                end else if (!is_digit(c)) begin
                    layout_ok = 1'b0;
                end else if (p <= 3) begin
                    year = year * 10 + d;
                end else if (p <= 6) begin
                    month = month * 10 + d;
                end else if (p <= 9) begin
                    day = day * 10 + d;
                end else if (p <= 12) begin
                    hour = hour * 10 + d;
                end else if (p <= 15) begin
                    minute = minute * 10 + d;
                end else begin
                    second = second * 10 + d;
                end
            end else if (p == 19) begin
                dot_seen = (c == CH_DOT);
            end else if (p <= 22) begin
                if (is_digit(c)) milli = milli * 10 + d;
                else milli_ok = 1'b0;
            end
            if (!is_space(c)) begin
                mark_pos  = p;
                mark_char = c;
            end
            if (pos < CONTENT_CAP) pos++;
        endfunction

        // accepted input transaction; the last character queues one expected result
        function void note_char(bit [15:0] c, bit last);
            bit     match;
            int     size;
            bit     good;
            bit [9:0] ms;
            longint v;
            stamp_t s;
            if (!seen_text) begin
                if (!is_space(c)) begin
                    seen_text = 1'b1;
                    if (c == CH_DQUOTE) quote = QT_DOUBLE;
                    else if (c == CH_SQUOTE) quote = QT_SINGLE;
                    else take_content(c);
                end
            end else begin
                take_content(c);
            end
            if (!last) return;

            if (quote != QT_NONE) begin
                match = (mark_char == (quote == QT_DOUBLE ? CH_DQUOTE : CH_SQUOTE));
                size  = mark_pos;
            end else begin
                match = 1'b1;
                size  = seen_text ? int'(mark_pos) + 1 : 0;
            end
            good = match && size >= 19 && layout_ok &&
                   month >= 1 && month <= 12 && day >= 1 && day <= 31 &&
                   hour <= 23 && minute <= 59 && second <= 60;
            if (good) begin
                ms = (size >= 23 && dot_seen && milli_ok) ? milli : 10'd0;
                v  = days_from_epoch(longint'(year), longint'(month), longint'(day));
                v  = ((v * 24 + longint'(hour)) * 60 + longint'(minute)) * 60000
                     + longint'(second) * 1000 + longint'(ms);
                s.status   = ST_CONVERTED;
                s.epoch_ms = v[48:0];
                n_converted++;
            end else begin
                s.status   = ST_FALLBACK;
                s.epoch_ms = '0;
                n_fallback++;
            end
            due_stamps.push_back(s);
            clear();
        endfunction

        task log_mismatch(string what);
            errors++;
            $display("result %0d: mismatch, %s", n_checked, what);
        endtask

        // accepted output transaction against the oldest expected result
        task check_stamp(bit status, bit [55:0] data);
            stamp_t want;
            n_checked++;
            if (due_stamps.size() == 0) begin
                log_mismatch("result with no string pending");
                return;
            end
            want = due_stamps.pop_front();
            if (status != want.status)
                log_mismatch($sformatf("status %0d, expected %0d", status, want.status));
            if (data[48:0] != want.epoch_ms)
                log_mismatch($sformatf("epoch_ms %0d, expected %0d",
                                       $signed(data[48:0]), $signed(want.epoch_ms)));
            if (data[55:49] != '0)
                log_mismatch($sformatf("pad bits 'h%0h, expected zero", data[55:49]));
        endtask
    endclass

endpackage

>>> test/testbench.sv
// Top of the timestamp converter testbench: clock, reset, drivers, monitor, watchdog.
module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    import epoch_scoreboard_pkg::*;

    localparam int PERIOD        = 10;
    localparam int RESET_CYCLES  = 7;
    localparam int RANDOM_CHARS  = 1400;
    localparam int MAX_WAIT      = 14;
    // Slowest legal gap between transactions: sender gap plus a full string
    // queue draining through receiver stalls.
    localparam int STALL_LIMIT   = 2000;
    localparam int SETTLE_CYCLES = 30;

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [15:0] s_tdata;     // [15:0] char_code
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic [55:0] m_tdata;     // [48:0] epoch_ms, [55:49] zero
    logic        m_tuser;     // [0] status

    epoch_scoreboard sb;
    bit [15:0]       text_q[$];   // characters of the string being built
    int              n_chars;
    int              n_strings;
    int              quiet_cycles;

    timestamp_text_to_epoch_ms dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #(PERIOD / 2) aclk = ~aclk;

    // ---------------------------------------------------------------- text building

    function automatic void put_char(bit [15:0] c);
        text_q.push_back(c);
    endfunction

    function automatic void put_str(string s);
        for (int i = 0; i < s.len(); i++) put_char(16'(s[i]));
    endfunction

    // fixed-width decimal field, leading zeros kept
    function automatic void put_num(int unsigned v, int n);
        int unsigned scale;
        scale = 1;
        repeat (n - 1) scale *= 10;
        for (int k = 0; k < n; k++) begin
            put_char(CH_ZERO + 16'((v / scale) % 10));
            scale /= 10;
        end
    endfunction

    function automatic bit [15:0] ws_char();
        int unsigned r;
        r = $urandom_range(0, 5);
        return (r == 5) ? CH_SPACE : CH_TAB + 16'(r);
    endfunction

    // any code unit, biased toward the ones the parser cares about
    function automatic bit [15:0] any_char();
        string seps;
        seps = "-: T.\"'";
        case ($urandom_range(0, 4))
            0:       return 16'($urandom);
            1:       return 16'($urandom_range(32, 126));
            2:       return CH_ZERO + 16'($urandom_range(0, 9));
            3:       return ws_char();
            default: return 16'(seps[$urandom_range(0, seps.len() - 1)]);
        endcase
    endfunction

    // mostly in range, sometimes any two-digit value
    function automatic int unsigned field_val(int unsigned lo, int unsigned hi);
        if ($urandom_range(0, 9) != 0) return $urandom_range(lo, hi);
        return $urandom_range(0, 99);
    endfunction

    // One random string: mostly well-formed timestamps with random fields,
    // wrapping and tails; some noise, some corrupted or cut short.
    function automatic void build_random();
        int        kind;
        int        len;
        quote_t    q;
        bit [15:0] qc;
        kind = $urandom_range(0, 9);
        if (kind == 0) begin
            len = $urandom_range(1, 30);
            repeat (len) put_char(any_char());
            return;
        end

        if ($urandom_range(0, 9) < 3) repeat ($urandom_range(1, 3)) put_char(ws_char());
        case ($urandom_range(0, 9))
            0, 1:    q = QT_DOUBLE;
            2, 3:    q = QT_SINGLE;
            default: q = QT_NONE;
        endcase
        qc = (q == QT_DOUBLE) ? CH_DQUOTE : CH_SQUOTE;
        if (q != QT_NONE) begin
            put_char(qc);
            if ($urandom_range(0, 9) == 0) put_char(ws_char());
        end

        if ($urandom_range(0, 7) == 0) put_num($urandom_range(0, 1) ? 9999 : 0, 4);
        else put_num($urandom_range(0, 9999), 4);
        put_char(CH_DASH);
        put_num(field_val(1, 12), 2);
        put_char(CH_DASH);
        put_num(field_val(1, 31), 2);
        put_char($urandom_range(0, 1) ? CH_T : CH_SPACE);
        put_num(field_val(0, 23), 2);
        put_char(CH_COLON);
        put_num(field_val(0, 59), 2);
        put_char(CH_COLON);
        put_num(field_val(0, 60), 2);

        case ($urandom_range(0, 5))
            1: begin
                put_char(CH_DOT);
                put_num($urandom_range(0, 999), 3);
            end
            2: begin
                put_char(CH_DOT);
                put_num($urandom_range(0, 99), 2);
            end
            3: begin
                put_char(CH_DOT);
                repeat (3) begin
                    if ($urandom_range(0, 4) != 0) put_num($urandom_range(0, 9), 1);
                    else put_char(any_char());
                end
            end
            4: begin
                put_char(CH_DOT);
                put_num($urandom_range(0, 999), 3);
                put_str("Z");
            end
            5: repeat ($urandom_range(1, 6)) put_char(any_char());
            default: ;
        endcase

        if (q != QT_NONE) begin
            case ($urandom_range(0, 9))
                8:       put_char((q == QT_DOUBLE) ? CH_SQUOTE : CH_DQUOTE);
                9:       ;
                default: put_char(qc);
            endcase
        end
        if ($urandom_range(0, 9) < 3) repeat ($urandom_range(1, 3)) put_char(ws_char());

        if (kind >= 8) begin
            repeat ($urandom_range(1, 2))
                text_q[$urandom_range(0, text_q.size() - 1)] = any_char();
        end else if (kind == 7 && $urandom_range(0, 1)) begin
            len = $urandom_range(1, text_q.size());
            text_q = text_q[0:len - 1];
        end
    endfunction

    // ---------------------------------------------------------------- drivers

    // Send the built string, one transaction per character, tlast on the final one.
    // A calm string has no gaps; otherwise a random gap may come before each character.
    task automatic send_text();
        bit calm;
        int gap;
        calm = ($urandom_range(0, 3) == 0);
        for (int i = 0; i < text_q.size(); i++) begin
            gap = calm ? 0 : $urandom_range(0, MAX_WAIT);
            if (gap != 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            s_tvalid <= 1'b1;
            s_tdata  <= text_q[i];
            s_tlast  <= (i == text_q.size() - 1);
            do @(posedge aclk); while (!s_tready);
        end
        n_strings++;
        n_chars += text_q.size();
        text_q.delete();
    endtask

    task automatic send_str(string s);
        put_str(s);
        send_text();
    endtask

    // Result side: a random stall before each result, with calm stretches.
    initial begin : result_sink
        int stall;
        int calm_left;
        bit calm;
        m_tready  = 1'b0;
        calm_left = 0;
        calm      = 1'b0;
        do @(posedge aclk); while (!aresetn);
        forever begin
            if (calm_left == 0) begin
                calm      = ($urandom_range(0, 2) == 0);
                calm_left = $urandom_range(1, 10);
            end
            calm_left--;
            stall = calm ? 0 : $urandom_range(0, MAX_WAIT);
            if (stall != 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
        end
    end

    // ---------------------------------------------------------------- monitor

    // Sampled at the rising edge, before any update of that edge lands.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) sb.note_char(s_tdata, s_tlast);
            if (m_tvalid && m_tready) sb.check_stamp(m_tuser, m_tdata);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles = 0;
            else quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("watchdog: no transaction for %0d cycles, %0d results outstanding",
                         quiet_cycles, sb.due_stamps.size());
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    // ---------------------------------------------------------------- main sequence

    initial begin : stimulus
        int start_chars;
        sb           = new();
        aresetn      = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        s_tlast      = 1'b0;
        n_chars      = 0;
        n_strings    = 0;
        quiet_cycles = 0;
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;

        // extremes of the range and the zero point
        send_str("0000-01-01 00:00:00");
        send_str("9999-12-31T23:59:60.999");
        send_str("1970-01-01 00:00:00.000");
        // whitespace and quote wrapping, day past month end, bad ms digit
        send_str(" \t \"2024-02-31 12:34:56.789\" \n");
        send_str("'2000-02-29T01:02:03.4x6'");
        // unmatched and mismatched quotes, whitespace kept inside quotes
        send_str("\"2021-06-15 10:20:30");
        send_str("'2021-06-15 10:20:30\"");
        send_str("\" 2021-06-15 10:20:30\"");
        // each field just out of range
        send_str("2021-13-01 00:00:00");
        send_str("2021-00-10 00:00:00");
        send_str("2021-01-00 00:00:00");
        send_str("2021-01-32 00:00:00");
        send_str("2021-01-01 24:00:00");
        send_str("2021-01-01 23:60:00");
        send_str("2021-01-01 23:59:61");
        // empty, quotes only, short, long, ms too short, no dot, bad separator
        send_str(" ");
        send_str("\"\"");
        send_str("2021-01-01 00:00");
        send_str("2021-01-01 00:00:00.123456789Z");
        send_str("2021-01-01 00:00:00.12");
        send_str("2021-01-01 00:00:00,123");
        send_str("2021/01/01 00:00:00");
        // code unit outside ASCII in the millisecond field
        put_str("2021-01-01 00:00:00.");
        put_char(16'hFFFF);
        put_str("00");
        send_text();

        start_chars = n_chars;
        while (n_chars - start_chars < RANDOM_CHARS) begin
            build_random();
            send_text();
        end
        s_tvalid <= 1'b0;

        while (sb.due_stamps.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);

        $display("covered %0d strings (%0d characters) with random gaps and stalls",
                 n_strings, n_chars);
        $display("%0d stamps converted, %0d fell back, %0d results checked",
                 sb.n_converted, sb.n_fallback, sb.n_checked);
        if (sb.errors == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
